FILE: hw/rtl/sse_pkg.sv
package sse_pkg;

   // Class codes of one letter, four bits wide: 0 is a non-letter, 1..6 a
   // consonant digit, and each of A E I O U H W Y has a code of its own.
   localparam logic [3:0] CLS_NONE = 4'd0;
   localparam logic [3:0] CLS_A    = 4'd7;
   localparam logic [3:0] CLS_E    = 4'd8;
   localparam logic [3:0] CLS_I    = 4'd9;
   localparam logic [3:0] CLS_O    = 4'd10;
   localparam logic [3:0] CLS_U    = 4'd11;
   localparam logic [3:0] CLS_H    = 4'd12;
   localparam logic [3:0] CLS_W    = 4'd13;
   localparam logic [3:0] CLS_Y    = 4'd14;

   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // Results of one accepted byte: a leading slot (first letter or the
   // digit of the run that ends), a second digit slot (run flushed by the
   // last byte) and the end marker.
   typedef struct packed {
      logic       a_vld;
      logic [7:0] a_char;
      logic       b_vld;
      logic [7:0] b_char;
      logic       mark;
   } sse_bundle_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } sse_qstat_type;

   // Uppercase ASCII letter that a Latin-1 byte folds to, 0 for no letter.
   function automatic logic [7:0] fold_letter(input logic [7:0] c);
      logic [7:0] f;
      f = 8'h00;
      if (c inside {[8'h41:8'h5A]}) begin
         f = c;
      end else if (c inside {[8'h61:8'h7A]}) begin
         f = c - 8'h20;
      end else if (c[7:6] == 2'b11) begin
         // upper and lower accented halves share one fold
         case (c[4:0])
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: f = "A";
            5'd7:                                     f = "S";
            5'd8, 5'd9, 5'd10:                        f = "E";
            5'd12, 5'd13, 5'd14, 5'd15:               f = "I";
            5'd17:                                    f = "N";
            5'd18, 5'd19, 5'd20, 5'd22, 5'd23, 5'd24: f = "O";
            5'd25, 5'd26, 5'd27, 5'd28:               f = "U";
            5'd29:                                    f = "Y";
            // sharp s folds to S; y-diaeresis is no letter here
            5'd31:                                    f = c[5] ? 8'h00 : "S";
            default:                                  f = 8'h00;
         endcase
      end
      return f;
   endfunction

   // Class of a folded uppercase letter, CLS_NONE for a zero byte.
   function automatic logic [3:0] class_of(input logic [7:0] l);
      logic [3:0] k;
      case (l)
         "B", "F", "P", "V":                     k = 4'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": k = 4'd2;
         "D", "T":                               k = 4'd3;
         "L":                                    k = 4'd4;
         "M", "N":                               k = 4'd5;
         "R":                                    k = 4'd6;
         "A":                                    k = CLS_A;
         "E":                                    k = CLS_E;
         "I":                                    k = CLS_I;
         "O":                                    k = CLS_O;
         "U":                                    k = CLS_U;
         "H":                                    k = CLS_H;
         "W":                                    k = CLS_W;
         "Y":                                    k = CLS_Y;
         default:                                k = CLS_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_digit(input logic [3:0] k);
      return (k >= 4'd1) && (k <= 4'd6);
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] k);
      return CHAR_ZERO + {4'b0000, k};
   endfunction

endpackage

FILE: hw/rtl/sse_front.sv
module sse_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // char_in[7:0]
   input  logic                   req_tlast,   // is_last_char
   input  sse_pkg::sse_qstat_type qstat,
   output logic                   push,
   output sse_pkg::sse_bundle_type push_data
);
   import sse_pkg::*;

   logic       found_ff, found_in;
   logic [3:0] pend_ff, pend_in;
   logic       accept;
   logic [7:0] letter;
   logic [3:0] cls;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign letter     = fold_letter(req_tdata);
   assign cls        = class_of(letter);

   // Classify the byte and build its results; advance the run state
   always_comb begin
      push_data = '0;
      found_in  = found_ff;
      pend_in   = pend_ff;
      if (!found_ff) begin
         if (letter != 8'h00) begin
            push_data.a_vld  = 1'b1;
            push_data.a_char = letter;
            found_in         = 1'b1;
            pend_in          = CLS_NONE;
         end
      end else begin
         if (cls != pend_ff) begin
            if (is_digit(pend_ff)) begin
               push_data.a_vld  = 1'b1;
               push_data.a_char = digit_char(pend_ff);
            end
            pend_in = cls;
         end
         // the run in progress is now of class cls either way
         if (req_tlast && is_digit(cls)) begin
            push_data.b_vld  = 1'b1;
            push_data.b_char = digit_char(cls);
         end
      end
      if (req_tlast) begin
         push_data.mark = 1'b1;
         found_in       = 1'b0;
         pend_in        = CLS_NONE;
      end
   end

   assign push = accept && (push_data.a_vld || push_data.b_vld || push_data.mark);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         pend_ff  <= CLS_NONE;
      end else if (accept) begin
         found_ff <= found_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

FILE: hw/rtl/sse_queue.sv
module sse_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sse_pkg::sse_bundle_type push_data,
   input  logic                    pop,
   output sse_pkg::sse_bundle_type head,
   output sse_pkg::sse_qstat_type  qstat
);
   import sse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sse_bundle_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_FULL);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/sse_back.sv
module sse_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sse_pkg::sse_bundle_type head,
   input  sse_pkg::sse_qstat_type  qstat,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,  // code_char[7:0]
   output logic                    rsp_tuser,  // char_valid
   output logic                    rsp_tlast   // code_done
);
   import sse_pkg::*;

   logic [2:0] sent_ff, sent_in;
   logic [2:0] rem, pick;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       cval_ff, cval_in;
   logic       done_ff, done_in;
   logic       load_ok, take;

   assign load_ok = !valid_ff || rsp_tready;
   assign take    = load_ok && !qstat.empty;

   // Pick the lowest result slot of the head bundle not yet sent
   assign rem  = {head.mark, head.b_vld, head.a_vld} & ~sent_ff;
   assign pick = rem & (~rem + 3'd1);
   assign pop  = take && ((rem & ~pick) == 3'b000);

   always_comb begin
      char_in = 8'h00;
      cval_in = 1'b0;
      done_in = 1'b0;
      case (pick)
         3'b001: begin
            char_in = head.a_char;
            cval_in = 1'b1;
         end
         3'b010: begin
            char_in = head.b_char;
            cval_in = 1'b1;
         end
         3'b100: begin
            done_in = 1'b1;
         end
         default: begin
            char_in = 8'h00;
         end
      endcase
   end

   // Track sent slots; clear once the bundle leaves the queue
   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = 3'b000;
      end else if (take) begin
         sent_in = sent_ff | pick;
      end
      valid_in = load_ok ? !qstat.empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= 3'b000;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the result register until its transfer
   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= char_in;
         cval_ff <= cval_in;
         done_ff <= done_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = cval_ff;
   assign rsp_tlast  = done_ff;

endmodule

FILE: hw/rtl/soundex_stream_encoder.sv
// Streaming phonetic encoder: one Latin-1 byte per transfer on req_, with
// req_tlast on the final byte of a symbol. The first letter goes out folded
// to ASCII uppercase, then the digits '1'..'6' of collapsed consonant runs,
// untruncated and unpadded, and every symbol closes with an end marker
// (rsp_tuser low, rsp_tdata zero, rsp_tlast high). A byte is accepted every
// cycle while the result queue between the classifier and the output stage
// has room; each byte makes zero to three results, and the output register
// sends one result per cycle while rsp_tready is high, so a run of bytes
// that each give at most one result streams at one byte per cycle. A result
// is queued and then registered for output. No clearing pass follows reset.
module soundex_stream_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_in[7:0]
   input  logic       req_tlast,   // is_last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // code_char[7:0]
   output logic       rsp_tuser,   // char_valid
   output logic       rsp_tlast    // code_done
);
   import sse_pkg::*;

   sse_qstat_type  qstat;
   sse_bundle_type push_data;
   sse_bundle_type head;
   logic           push;
   logic           pop;

   sse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   sse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   sse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sim/soundex_code_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the phonetic encoder, predicts the code
// characters of every accepted byte and compares each result transfer with
// the oldest prediction still waiting.
module soundex_code_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // char_in[7:0]
   input  logic       req_tlast,    // is_last_char
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // code_char[7:0]
   input  logic       rsp_tuser,    // char_valid
   input  logic       rsp_tlast,    // code_done
   output int         fail_count,
   output int         outstanding
);

   import sse_pkg::*;

   typedef struct packed {
      logic [7:0] code_char;
      logic       char_valid;
      logic       code_done;
   } code_item_type;

   localparam logic [3:0] DIGIT_LO = 4'd1;
   localparam logic [3:0] DIGIT_HI = 4'd6;

   code_item_type code_q[$];
   logic          seen_letter;
   logic [3:0]    run_class;

   // Uppercase ASCII letter of a Latin-1 byte, zero for a non-letter.
   function automatic logic [7:0] fold_latin1(input logic [7:0] b);
      logic [7:0] up;
      logic [7:0] lo;
      up = 8'h00;
      // map the upper accented half onto the lower one
      lo = b | 8'h20;
      if (b >= "A" && b <= "Z") begin
         up = b;
      end else if (b >= "a" && b <= "z") begin
         up = b - 8'h20;
      end else if (b == 8'hDF) begin
         up = "S";
      end else if (b >= 8'hC0) begin
         if (lo <= 8'hE6) up = "A";
         else if (lo == 8'hE7) up = "S";
         else if (lo <= 8'hEA) up = "E";
         else if (lo >= 8'hEC && lo <= 8'hEF) up = "I";
         else if (lo == 8'hF1) up = "N";
         else if (lo >= 8'hF2 && lo <= 8'hF4) up = "O";
         else if (lo >= 8'hF6 && lo <= 8'hF8) up = "O";
         else if (lo >= 8'hF9 && lo <= 8'hFC) up = "U";
         else if (lo == 8'hFD) up = "Y";
      end
      return up;
   endfunction

   // Class of a folded letter; consonants give their digit.
   function automatic logic [3:0] phonetic_class(input logic [7:0] up);
      logic [3:0] k;
      case (up)
         "B", "F", "P", "V":                     k = 4'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": k = 4'd2;
         "D", "T":                               k = 4'd3;
         "L":                                    k = 4'd4;
         "M", "N":                               k = 4'd5;
         "R":                                    k = 4'd6;
         "A":                                    k = CLS_A;
         "E":                                    k = CLS_E;
         "I":                                    k = CLS_I;
         "O":                                    k = CLS_O;
         "U":                                    k = CLS_U;
         "H":                                    k = CLS_H;
         "W":                                    k = CLS_W;
         "Y":                                    k = CLS_Y;
         default:                                k = CLS_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_code_digit(input logic [3:0] k);
      return k >= DIGIT_LO && k <= DIGIT_HI;
   endfunction

   // Advance the encoder state by one byte and queue the code it produces.
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] up;
      logic [3:0] k;
      up = fold_latin1(b);
      if (!seen_letter) begin
         if (up != 8'h00) begin
            code_q.push_back('{up, 1'b1, 1'b0});
            seen_letter = 1'b1;
            run_class = CLS_NONE;
         end
      end else begin
         k = phonetic_class(up);
         // a class change closes the current run
         if (k != run_class) begin
            if (is_code_digit(run_class))
               code_q.push_back('{CHAR_ZERO + {4'b0000, run_class}, 1'b1, 1'b0});
            run_class = k;
         end
         // the final byte flushes the open run
         if (fin && is_code_digit(run_class))
            code_q.push_back('{CHAR_ZERO + {4'b0000, run_class}, 1'b1, 1'b0});
      end
      if (fin) begin
         code_q.push_back('{8'h00, 1'b0, 1'b1});
         seen_letter = 1'b0;
         run_class = CLS_NONE;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0d ns: %s", $time, msg);
      fail_count++;
   endtask

   // Predict on each byte transfer, compare on each result transfer.
   always @(posedge clock) begin
      code_item_type want;
      if (reset) begin
         seen_letter = 1'b0;
         run_class = CLS_NONE;
         code_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (code_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result data=%h user=%b last=%b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = code_q.pop_front();
               if (rsp_tdata !== want.code_char)
                  report_mismatch($sformatf("code_char %h, expected %h",
                                            rsp_tdata, want.code_char));
               if (rsp_tuser !== want.char_valid)
                  report_mismatch($sformatf("char_valid %b, expected %b",
                                            rsp_tuser, want.char_valid));
               if (rsp_tlast !== want.code_done)
                  report_mismatch($sformatf("code_done %b, expected %b",
                                            rsp_tlast, want.code_done));
            end
         end
      end
      outstanding <= code_q.size();
   end

endmodule

FILE: sim/tb_soundex_stream_encoder.sv
`timescale 1ns / 1ps

module tb_soundex_stream_encoder;

   localparam int RANDOM_ITEMS = 420;
   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 4;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // char_in[7:0]
   logic       req_tlast = 1'b0;    // is_last_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // code_char[7:0]
   logic       rsp_tuser;           // char_valid
   logic       rsp_tlast;           // code_done

   int             fail_count;
   int             outstanding;
   int             burst_left = 0;
   int             bytes_sent = 0;
   int             idle_cycles = 0;
   logic [7:0]     symbol_q[$];
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [7:0]     ready_pattern = 8'hFF;
   int             ready_phase = 0;

   always #5 clock = ~clock;

   soundex_stream_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   soundex_code_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Stall the result side: phases of always ready, coin flips, or a
   // rotating pattern that is never all low.
   always @(posedge clock) begin
      if (ready_phase == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         ready_pattern <= 8'($urandom_range(1, 255));
         ready_phase <= $urandom_range(8, 64);
      end else begin
         ready_phase <= ready_phase - 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ready_pattern[0];
      endcase
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one byte and hold it until transfer; open a gap before most bursts.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic send_symbol();
      for (int i = 0; i < symbol_q.size(); i++)
         send_byte(symbol_q[i], i == symbol_q.size() - 1);
   endtask

   // Hold off the sender until every predicted result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Build a symbol: mostly letters with repeats and accents, some noise.
   task automatic make_symbol();
      int         len;
      int         pick;
      logic [7:0] b;
      symbol_q.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            b = 8'h41 + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1) b = b + 8'h20;
         end else if (pick < 70) begin
            b = 8'($urandom_range(8'hC0, 8'hFF));
         end else if (pick < 85 && i > 0) begin
            b = symbol_q[i - 1];
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         symbol_q.push_back(b);
      end
      // now and then a symbol with no letter at all
      if ($urandom_range(0, 19) == 0) begin
         foreach (symbol_q[i]) symbol_q[i] = 8'($urandom_range(0, 8'h40));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero byte, high-half gap and y-diaeresis: only the end marker
      symbol_q = '{8'h00, 8'h80, 8'hFF};
      send_symbol();
      // first letter on the final byte
      symbol_q = '{"q"};
      send_symbol();
      // same digit split by H and by a non-letter, D7 folding to O
      symbol_q = '{8'h7F, "a", "B", "h", "B", 8'hCB, "f", 8'hD7};
      send_symbol();
      // c-cedilla first, digits 2 to 6, two digits out on the last byte
      symbol_q = '{8'hC7, "d", "l", "m", "r", "c", "t"};
      send_symbol();
      // sharp s first, y-diaeresis inside, digit flushed at the end
      symbol_q = '{8'hDF, 8'hFF, "p"};
      send_symbol();
      // accented vowel first, collapsed run of one class
      symbol_q = '{8'hE9, "k", "x"};
      send_symbol();
      wait_drained();

      while (bytes_sent < RANDOM_ITEMS) begin
         make_symbol();
         send_symbol();
         bytes_sent += symbol_q.size();
         if ($urandom_range(0, 14) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
